[src/bba_pkg.sv]
// Shared types and constants for the buddy block allocator.
package bba_pkg;

    localparam int DEF_MAX_ORDER    = 16;
    localparam int DEF_MIN_ORDER    = 4;
    localparam int DEF_HEADER_BYTES = 16;

    localparam int SIZE_W = 16;   // request size field
    localparam int OFF_W  = 16;   // pool offsets, data offset field
    localparam int GORD_W = 5;    // granted order field
    localparam int NEED_W = 17;   // size plus header
    localparam int ORD_W  = 6;    // order values 0..MAX_ORDER+1

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified request, front to back
    typedef struct packed {
        logic             reject;
        logic [ORD_W-1:0] want;
    } cls_t;

    // result word
    typedef struct packed {
        logic              granted;
        logic [OFF_W-1:0]  data_offset;
        logic [GORD_W-1:0] order;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_READ,
        ST_SPLIT,
        ST_DONE
    } st_t;

endpackage

[src/bba_front.sv]
// Request classifier: needed block order and reject flag.
module bba_front
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int MIN_ORDER    = DEF_MIN_ORDER,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic [SIZE_W-1:0] request_bytes,
    output cls_t              cls
);

    logic [NEED_W-1:0] need;
    logic [NEED_W-1:0] need_m1;
    logic [ORD_W-1:0]  msb;
    logic [ORD_W-1:0]  ceil_log2;
    logic [ORD_W-1:0]  want;

    always_comb
    begin
        need    = NEED_W'(request_bytes) + NEED_W'(HEADER_BYTES);
        need_m1 = need - NEED_W'(1);
        msb     = '0;
        for (int i = 0; i < NEED_W; i++)
        begin
            if (need_m1[i])
            begin
                msb = ORD_W'(i);
            end
        end
        // ceil(log2(need)); need of one fits order zero
        ceil_log2 = (need_m1 == '0) ? '0 : msb + ORD_W'(1);
        want      = (ceil_log2 < ORD_W'(MIN_ORDER)) ? ORD_W'(MIN_ORDER) : ceil_log2;

        cls.want   = want;
        cls.reject = (request_bytes == '0) || (want > ORD_W'(MAX_ORDER));
    end

endmodule

[src/bba_queue.sv]
// Small FIFO of classified requests between front and back.
module bba_queue
    import bba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cls_t pop_data
);

    cls_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/bba_back.sv]
// Allocation engine: free-order search, block take, split walk, result register.
module bba_back
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cls_t q_entry,
    output logic q_pop,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int AW        = $clog2(MAX_ORDER);
    localparam int MEM_DEPTH = 1 << AW;

    // offsets of free blocks below the top order; top order offset is always 0
    logic [OFF_W-1:0] mem [MEM_DEPTH];
    logic [OFF_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [OFF_W-1:0] wr_data;

    st_t              state_reg, state_next;
    logic [MAX_ORDER:0] free_reg, free_next;
    logic [ORD_W-1:0] want_reg, want_next;
    logic [ORD_W-1:0] src_reg, src_next;
    logic [ORD_W-1:0] j_reg, j_next;
    logic [OFF_W-1:0] base_reg, base_next;
    logic             granted_reg, granted_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             found;
    logic [ORD_W-1:0] src_c;
    logic [ORD_W-1:0] jm1;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        want_next      = want_reg;
        src_next       = src_reg;
        j_next         = j_reg;
        base_next      = base_reg;
        granted_next   = granted_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;

        // lowest free order at or above the wanted one
        found = 1'b0;
        src_c = '0;
        for (int i = MAX_ORDER; i >= 0; i--)
        begin
            if (free_reg[i] && (ORD_W'(i) >= want_reg))
            begin
                found = 1'b1;
                src_c = ORD_W'(i);
            end
        end
        rd_addr = src_c[AW-1:0];

        jm1     = j_reg - ORD_W'(1);
        wr_addr = jm1[AW-1:0];
        wr_data = base_reg + (OFF_W'(1) << jm1);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    want_next = q_entry.want;
                    if (q_entry.reject)
                    begin
                        granted_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (found)
                begin
                    src_next = src_c;
                    for (int i = 0; i <= MAX_ORDER; i++)
                    begin
                        if (ORD_W'(i) == src_c)
                        begin
                            free_next[i] = 1'b0;
                        end
                    end
                    state_next = ST_READ;
                end
                else
                begin
                    granted_next = 1'b0;
                    state_next   = ST_DONE;
                end
            end
            ST_READ:
            begin
                base_next  = (src_reg == ORD_W'(MAX_ORDER)) ? '0 : rd_data_reg;
                j_next     = src_reg;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                if (j_reg == want_reg)
                begin
                    granted_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    // upper half of the split block becomes free one order down
                    wr_en = 1'b1;
                    for (int i = 0; i <= MAX_ORDER; i++)
                    begin
                        if (ORD_W'(i) == jm1)
                        begin
                            free_next[i] = 1'b1;
                        end
                    end
                    j_next = jm1;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    if (granted_reg)
                    begin
                        rsp_next.granted     = 1'b1;
                        rsp_next.data_offset = base_reg + OFF_W'(HEADER_BYTES);
                        rsp_next.order       = GORD_W'(want_reg);
                    end
                    else
                    begin
                        rsp_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            free_reg      <= {1'b1, MAX_ORDER'(0)};
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg    <= want_next;
        src_reg     <= src_next;
        j_reg       <= j_next;
        base_reg    <= base_next;
        granted_reg <= granted_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

[src/buddy_block_allocate_core.sv]
// Top level of the buddy block allocator (allocation side).
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  request  | req_valid / req_ready| request_bytes[15:0]
//  result   | rsp_valid / rsp_ready| granted, data_offset[15:0], granted_order[4:0]
//
// One result per request, in request order.
// Rejected request (zero size, too large): engine goes from IDLE to DONE.
// Pool exhausted: IDLE, SEARCH, DONE. Grant: IDLE, SEARCH, READ, SPLIT for
// each order from the source order down to the wanted one, then DONE; the
// split walk writes one buddy offset per cycle to offset memory (one write port).
// Reset: only the top order is free; no clearing pass, ready right away.
// A two-entry queue keeps taking requests while the engine works or a result
// waits; req_ready drops only when that queue is full.
module buddy_block_allocate_core
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int MIN_ORDER    = DEF_MIN_ORDER,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [SIZE_W-1:0] request_bytes,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              granted,
    output logic [OFF_W-1:0]  data_offset,
    output logic [GORD_W-1:0] granted_order
);

    cls_t cls_in;      // classified incoming request
    cls_t cls_out;     // head of the queue
    logic q_full;
    logic q_not_empty;
    logic q_pop;
    rsp_t rsp;

    // front: size to order, reject checks
    bba_front #(
        .MAX_ORDER    (MAX_ORDER),
        .MIN_ORDER    (MIN_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .request_bytes (request_bytes),
        .cls           (cls_in)
    );

    assign req_ready = !q_full;

    // decouples front from the allocation engine
    bba_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid && req_ready),
        .push_data (cls_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (cls_out)
    );

    // back: search, take, split, result register
    bba_back #(
        .MAX_ORDER    (MAX_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_entry   (cls_out),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    assign granted       = rsp.granted;
    assign data_offset   = rsp.data_offset;
    assign granted_order = rsp.order;

endmodule

[src/bba_checker.sv]
// Port-level checks for the buddy block allocator, bound to the top level.
module bba_checker
    import bba_pkg::*;
#(
    parameter int MAX_ORDER    = DEF_MAX_ORDER,
    parameter int MIN_ORDER    = DEF_MIN_ORDER,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              granted,
    input logic [OFF_W-1:0]  data_offset,
    input logic [GORD_W-1:0] granted_order
);

    logic [OFF_W-1:0] block_off;
    logic [OFF_W-1:0] align_mask;

    assign block_off  = data_offset - OFF_W'(HEADER_BYTES);
    assign align_mask = OFF_W'((64'd1 << granted_order) - 64'd1);

    // null result carries zero fields
    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !granted) |-> (data_offset == '0 && granted_order == '0))
        else $error("null result with nonzero fields");

    // granted order within configured bounds
    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && granted) |->
            (granted_order >= GORD_W'(MIN_ORDER) && 32'(granted_order) <= MAX_ORDER))
        else $error("granted order out of range");

    // granted block is aligned to its own size
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && granted) |-> ((block_off & align_mask) == '0))
        else $error("granted block not aligned to its order");

    // held result does not change
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(granted) && $stable(data_offset)
             && $stable(granted_order)))
        else $error("stalled result changed");

endmodule

bind buddy_block_allocate_core bba_checker #(
    .MAX_ORDER    (MAX_ORDER),
    .MIN_ORDER    (MIN_ORDER),
    .HEADER_BYTES (HEADER_BYTES)
) u_bba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .granted       (granted),
    .data_offset   (data_offset),
    .granted_order (granted_order)
);
